// ===== rtl/core/oft_pkg.sv =====
// ----------------------------------------------------------------------------
// oft_pkg: option file tokenizer shared types
// Request structs, scanner state and character codes.
// ----------------------------------------------------------------------------
package oft_pkg;

	localparam int RBUF_DEPTH = 4;
	localparam int RBUF_AW    = $clog2(RBUF_DEPTH);
	localparam int MAX_RES    = 3;
	localparam int RES_NW     = $clog2(MAX_RES + 1);

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	localparam logic [1:0] KIND_VAR = 2'd0;
	localparam logic [1:0] KIND_VAL = 2'd1;
	localparam logic [1:0] KIND_EOI = 2'd2;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_WORD  = 3'd1,
		MODE_QUOTE = 3'd2,
		MODE_BLOCK = 3'd3,
		MODE_LINE  = 3'd4
	} mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} chr_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] token_byte;
		logic       byte_valid;
		logic       token_end;
	} tok_t;

	typedef struct packed {
		mode_t scan_mode;
		logic  expect_variable;
		logic  token_kind;
		logic  token_open;
		logic  slash_pending;
		logic  prev_backslash;
		logic  star_seen;
	} scan_t;

	localparam scan_t SCAN_RESET = '{
		scan_mode:       MODE_IDLE,
		expect_variable: 1'b1,
		token_kind:      1'b0,
		token_open:      1'b0,
		slash_pending:   1'b0,
		prev_backslash:  1'b0,
		star_seen:       1'b0
	};

endpackage

// ===== rtl/core/oft_step.sv =====
// ----------------------------------------------------------------------------
// oft_step: scanner next-state logic
// Given the scanner state and one character request, produces the next
// state and up to three token requests.
// ----------------------------------------------------------------------------
module oft_step (
	input  oft_pkg::scan_t              cur,
	input  oft_pkg::chr_t               chr,
	output oft_pkg::scan_t              nxt,
	output oft_pkg::tok_t               res [oft_pkg::MAX_RES],
	output logic [oft_pkg::RES_NW-1:0]  res_n
);
	import oft_pkg::*;

	function automatic tok_t mk(input logic [1:0] k, input logic [7:0] b,
	                            input logic v, input logic e);
		tok_t t;
		t.kind       = k;
		t.token_byte = b;
		t.byte_valid = v;
		t.token_end  = e;
		return t;
	endfunction

	function automatic logic [1:0] kcode(input logic tk);
		return tk ? KIND_VAL : KIND_VAR;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	logic [7:0] c;
	logic       do_word;

	always_comb begin
		c       = chr.ch;
		nxt     = cur;
		do_word = 1'b0;
		res_n   = '0;
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '0;
		end

		if (chr.end_of_input) begin
			if (cur.slash_pending) begin
				if (!nxt.token_open) begin
					nxt.token_kind      = !nxt.expect_variable;
					nxt.expect_variable = 1'b0;
					nxt.token_open      = 1'b1;
				end
				res[res_n[1:0]] = mk(kcode(nxt.token_kind), CH_SLASH, 1'b1, 1'b0);
				res_n = res_n + RES_NW'(1);
			end
			if (nxt.token_open) begin
				res[res_n[1:0]] = mk(kcode(nxt.token_kind), 8'h00, 1'b0, 1'b1);
				res_n = res_n + RES_NW'(1);
			end
			res[res_n[1:0]] = mk(KIND_EOI, 8'h00, 1'b0, 1'b0);
			res_n = res_n + RES_NW'(1);
			nxt = SCAN_RESET;
		end else if (cur.slash_pending) begin
			nxt.slash_pending = 1'b0;
			if (c == CH_STAR || c == CH_SLASH) begin
				if (nxt.token_open) begin
					res[res_n[1:0]] = mk(kcode(nxt.token_kind), 8'h00, 1'b0, 1'b1);
					res_n = res_n + RES_NW'(1);
					nxt.token_open     = 1'b0;
					nxt.prev_backslash = 1'b0;
				end
				nxt.scan_mode = (c == CH_STAR) ? MODE_BLOCK : MODE_LINE;
				nxt.star_seen = 1'b0;
			end else begin
				if (!nxt.token_open) begin
					nxt.token_kind      = !nxt.expect_variable;
					nxt.expect_variable = 1'b0;
					nxt.token_open      = 1'b1;
					nxt.scan_mode       = MODE_WORD;
					nxt.prev_backslash  = 1'b0;
				end
				res[res_n[1:0]] = mk(kcode(nxt.token_kind), CH_SLASH, 1'b1, 1'b0);
				res_n = res_n + RES_NW'(1);
				do_word = 1'b1;
			end
		end else begin
			unique case (cur.scan_mode)
				MODE_WORD: begin
					do_word = 1'b1;
				end
				MODE_QUOTE: begin
					if (cur.prev_backslash) begin
						nxt.prev_backslash = 1'b0;
						res[res_n[1:0]] = mk(kcode(nxt.token_kind), c, 1'b1, 1'b0);
						res_n = res_n + RES_NW'(1);
					end else if (c == CH_BSL) begin
						nxt.prev_backslash = 1'b1;
					end else if (c == CH_QUOTE) begin
						res[res_n[1:0]] = mk(kcode(nxt.token_kind), 8'h00, 1'b0, 1'b1);
						res_n = res_n + RES_NW'(1);
						nxt.token_open     = 1'b0;
						nxt.scan_mode      = MODE_IDLE;
						nxt.prev_backslash = 1'b0;
					end else begin
						res[res_n[1:0]] = mk(kcode(nxt.token_kind), c, 1'b1, 1'b0);
						res_n = res_n + RES_NW'(1);
					end
				end
				MODE_BLOCK: begin
					if (cur.star_seen && c == CH_SLASH) begin
						nxt.scan_mode = MODE_IDLE;
						nxt.star_seen = 1'b0;
					end else begin
						nxt.star_seen = (c == CH_STAR);
					end
				end
				MODE_LINE: begin
					if (c == CH_NL) begin
						nxt.scan_mode       = MODE_IDLE;
						nxt.expect_variable = 1'b1;
					end
				end
				default: begin
					nxt.scan_mode = MODE_IDLE;
					if (is_space(c)) begin
						if (c == CH_NL) begin
							nxt.expect_variable = 1'b1;
						end
					end else if (c == CH_SLASH) begin
						nxt.slash_pending = 1'b1;
					end else begin
						nxt.token_kind      = !nxt.expect_variable;
						nxt.expect_variable = 1'b0;
						nxt.token_open      = 1'b1;
						nxt.prev_backslash  = 1'b0;
						if (c == CH_QUOTE) begin
							nxt.scan_mode = MODE_QUOTE;
						end else begin
							nxt.scan_mode = MODE_WORD;
							res[res_n[1:0]] = mk(kcode(nxt.token_kind), c, 1'b1, 1'b0);
							res_n = res_n + RES_NW'(1);
						end
					end
				end
			endcase
		end

		// character inside a word with no slash held
		if (do_word) begin
			if (is_space(c)) begin
				if (c == CH_NL && nxt.token_kind) begin
					nxt.expect_variable = 1'b1;
				end
				res[res_n[1:0]] = mk(kcode(nxt.token_kind), 8'h00, 1'b0, 1'b1);
				res_n = res_n + RES_NW'(1);
				nxt.token_open     = 1'b0;
				nxt.scan_mode      = MODE_IDLE;
				nxt.prev_backslash = 1'b0;
			end else if (c == CH_SLASH) begin
				nxt.slash_pending = 1'b1;
			end else begin
				res[res_n[1:0]] = mk(kcode(nxt.token_kind), c, 1'b1, 1'b0);
				res_n = res_n + RES_NW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/oft_rbuf.sv =====
// ----------------------------------------------------------------------------
// oft_rbuf: token request buffer
// Small register FIFO taking up to three requests per cycle when there is
// room and delivering one per cycle on the output channel unless stalled.
// ----------------------------------------------------------------------------
module oft_rbuf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_req,
	input  logic [oft_pkg::RES_NW-1:0]  wr_n,
	input  oft_pkg::tok_t               wr_data [oft_pkg::MAX_RES],
	output logic                        wr_ok,
	output logic                        valid,
	input  logic                        stall,
	output oft_pkg::tok_t               tok
);
	import oft_pkg::*;

	tok_t               mem_q [RBUF_DEPTH];
	logic [RBUF_AW-1:0] head_q;
	logic [RBUF_AW-1:0] tail_q;
	logic [RBUF_AW:0]   cnt_q;
	logic [RBUF_AW+1:0] free;
	logic               pop;
	logic               wr;

	assign valid = (cnt_q != '0);
	assign tok   = mem_q[head_q];
	assign pop   = valid && !stall;
	assign free  = (RBUF_AW+2)'(RBUF_DEPTH) - {1'b0, cnt_q} + {{(RBUF_AW+1){1'b0}}, pop};
	assign wr_ok = ((RBUF_AW+2)'(wr_n) <= free);
	assign wr    = wr_req && wr_ok;

	always_ff @(posedge clk) begin
		if (wr) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (RES_NW'(i) < wr_n) begin
					mem_q[tail_q + RBUF_AW'(i)] <= wr_data[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + RBUF_AW'(1);
			end
			if (wr) begin
				tail_q <= tail_q + RBUF_AW'(wr_n);
			end
			cnt_q <= cnt_q + (wr ? (RBUF_AW+1)'(wr_n) : '0) - (RBUF_AW+1)'(pop);
		end
	end

endmodule

// ===== rtl/core/option_file_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// option_file_tokenizer_unit: streaming option file tokenizer
// Skips whitespace and comments and streams token bytes tagged as
// variable or value, with end markers and an end-of-input request.
//
//   channel  dir  payload  handshake
//   chr      in   chr_t    chr_valid / chr_stall
//   tok      out  tok_t    tok_valid / tok_stall
//
// A character is registered in chr_s1, scanned from there, and its token
// requests (zero to three) land in a four-entry output FIFO. One character
// per clock is taken while each yields at most one request and tok is not
// stalled; tok moves one request per clock unless stalled, so items that
// yield more can fill the FIFO and stall chr. arst_n returns the scanner to
// between-tokens with a variable expected and empties the FIFO.
// ----------------------------------------------------------------------------
module option_file_tokenizer_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           chr_valid,
	output logic           chr_stall,
	input  oft_pkg::chr_t  chr,
	output logic           tok_valid,
	input  logic           tok_stall,
	output oft_pkg::tok_t  tok
);
	import oft_pkg::*;

	chr_t              chr_s1;
	logic              vld_s1;
	scan_t             scan_q;
	scan_t             scan_nxt;
	tok_t              res [MAX_RES];
	logic [RES_NW-1:0] res_n;
	logic              wr_ok;
	logic              proc;

	assign proc      = vld_s1 && wr_ok;
	assign chr_stall = vld_s1 && !wr_ok;

	always_ff @(posedge clk) begin
		if (!chr_stall && chr_valid) begin
			chr_s1 <= chr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			scan_q <= SCAN_RESET;
		end else begin
			if (!chr_stall) begin
				vld_s1 <= chr_valid;
			end
			if (proc) begin
				scan_q <= scan_nxt;
			end
		end
	end

	oft_step u_step (
		.cur   (scan_q),
		.chr   (chr_s1),
		.nxt   (scan_nxt),
		.res   (res),
		.res_n (res_n)
	);

	oft_rbuf u_rbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_req  (vld_s1),
		.wr_n    (res_n),
		.wr_data (res),
		.wr_ok   (wr_ok),
		.valid   (tok_valid),
		.stall   (tok_stall),
		.tok     (tok)
	);

endmodule

// ===== tb/option_file_tokenizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// option_file_tokenizer_unit_tb: self-checking bench for the option file
// tokenizer. Characters go in on chr and tok is drained, both with random
// gaps while gaps_on is set. A local scanner model predicts every token
// request, and each request is compared field by field in order.
// ----------------------------------------------------------------------------
module option_file_tokenizer_unit_tb;

	import oft_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 80;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  chr_valid = 1'b0;
	logic  chr_stall;
	chr_t  chr       = '0;
	logic  tok_valid;
	logic  tok_stall = 1'b0;
	tok_t  tok;

	scan_t scan = SCAN_RESET;
	tok_t  expected_toks[$];
	int    chars_sent  = 0;
	int    errors      = 0;
	int    idle_cycles = 0;
	bit    gaps_on     = 1'b1;
	int    hold_len    = 0;

	option_file_tokenizer_unit u_top (
		.clk,
		.arst_n,
		.chr_valid,
		.chr_stall,
		.chr,
		.tok_valid,
		.tok_stall,
		.tok
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---- scanner model ----

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [1:0] open_kind();
		return scan.token_kind ? KIND_VAL : KIND_VAR;
	endfunction

	function automatic void push_tok(input logic [1:0] k, input logic [7:0] b,
			input logic v, input logic e);
		tok_t t;
		t.kind       = k;
		t.token_byte = b;
		t.byte_valid = v;
		t.token_end  = e;
		expected_toks = {expected_toks, t};
	endfunction

	function automatic void open_token(input mode_t m);
		scan.token_kind      = ~scan.expect_variable;
		scan.expect_variable = 1'b0;
		scan.token_open      = 1'b1;
		scan.scan_mode       = m;
		scan.prev_backslash  = 1'b0;
	endfunction

	function automatic void close_token();
		push_tok(open_kind(), 8'h00, 1'b0, 1'b1);
		scan.token_open     = 1'b0;
		scan.scan_mode      = MODE_IDLE;
		scan.prev_backslash = 1'b0;
	endfunction

	function automatic void word_step(input logic [7:0] c);
		if (is_blank(c)) begin
			if (c == CH_NL && scan.token_kind)
				scan.expect_variable = 1'b1;
			close_token();
		end else if (c == CH_SLASH) begin
			scan.slash_pending = 1'b1;
		end else begin
			push_tok(open_kind(), c, 1'b1, 1'b0);
		end
	endfunction

	function automatic void tokenize_char(input chr_t c);
		if (c.end_of_input) begin
			if (scan.slash_pending) begin
				if (!scan.token_open)
					open_token(MODE_WORD);
				push_tok(open_kind(), CH_SLASH, 1'b1, 1'b0);
			end
			if (scan.token_open)
				close_token();
			push_tok(KIND_EOI, 8'h00, 1'b0, 1'b0);
			scan = SCAN_RESET;
			return;
		end
		if (scan.slash_pending) begin
			scan.slash_pending = 1'b0;
			if (c.ch == CH_STAR || c.ch == CH_SLASH) begin
				if (scan.token_open)
					close_token();
				if (c.ch == CH_STAR)
					scan.scan_mode = MODE_BLOCK;
				else
					scan.scan_mode = MODE_LINE;
				scan.star_seen = 1'b0;
				return;
			end
			if (!scan.token_open)
				open_token(MODE_WORD);
			push_tok(open_kind(), CH_SLASH, 1'b1, 1'b0);
			word_step(c.ch);
			return;
		end
		case (scan.scan_mode)
			MODE_WORD: word_step(c.ch);
			MODE_QUOTE: begin
				if (scan.prev_backslash) begin
					scan.prev_backslash = 1'b0;
					push_tok(open_kind(), c.ch, 1'b1, 1'b0);
				end else if (c.ch == CH_BSL) begin
					scan.prev_backslash = 1'b1;
				end else if (c.ch == CH_QUOTE) begin
					close_token();
				end else begin
					push_tok(open_kind(), c.ch, 1'b1, 1'b0);
				end
			end
			MODE_BLOCK: begin
				if (scan.star_seen && c.ch == CH_SLASH) begin
					scan.scan_mode = MODE_IDLE;
					scan.star_seen = 1'b0;
				end else begin
					scan.star_seen = (c.ch == CH_STAR);
				end
			end
			MODE_LINE: begin
				if (c.ch == CH_NL) begin
					scan.scan_mode       = MODE_IDLE;
					scan.expect_variable = 1'b1;
				end
			end
			default: begin
				scan.scan_mode = MODE_IDLE;
				if (is_blank(c.ch)) begin
					if (c.ch == CH_NL)
						scan.expect_variable = 1'b1;
				end else if (c.ch == CH_SLASH) begin
					scan.slash_pending = 1'b1;
				end else if (c.ch == CH_QUOTE) begin
					open_token(MODE_QUOTE);
				end else begin
					open_token(MODE_WORD);
					push_tok(open_kind(), c.ch, 1'b1, 1'b0);
				end
			end
		endcase
	endfunction

	// ---- chr side ----

	task automatic send_char(input logic [7:0] c, input logic eoi);
		chr_t pkt;
		int   gap;
		pkt.ch           = eoi ? 8'($urandom_range(0, 255)) : c;
		pkt.end_of_input = eoi;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			chr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chr_valid <= 1'b1;
		chr       <= pkt;
		do @(posedge clk); while (chr_stall !== 1'b0);
		tokenize_char(pkt);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_char(s[i], 1'b0);
	endtask

	task automatic drain_results();
		chr_valid <= 1'b0;
		while (expected_toks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		b = 8'($urandom_range(CH_SP + 1, 255));
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		logic [7:0] b;
		b = 8'($urandom_range(CH_TAB, CH_CR + 1));
		return (b > CH_CR) ? CH_SP : b;
	endfunction

	task automatic send_random_piece();
		int         n;
		logic [7:0] b;
		case ($urandom_range(0, 11)) inside
			[0:3]: begin
				n = $urandom_range(1, 4);
				repeat (n) send_char(word_byte(), 1'b0);
				send_char(blank_byte(), 1'b0);
			end
			[4:6]: begin
				send_char(CH_QUOTE, 1'b0);
				n = $urandom_range(0, 4);
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_QUOTE || b == CH_BSL || $urandom_range(0, 3) == 0)
						send_char(CH_BSL, 1'b0);
					send_char(b, 1'b0);
				end
				send_char(CH_QUOTE, 1'b0);
			end
			7: begin
				send_text("/*");
				n = $urandom_range(0, 3);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: send_char(CH_STAR, 1'b0);
						1: send_char(CH_SLASH, 1'b0);
						default: send_char(word_byte(), 1'b0);
					endcase
				end
				send_text("*/");
			end
			8: begin
				send_text("//");
				n = $urandom_range(0, 3);
				repeat (n) send_char(word_byte(), 1'b0);
				send_char(CH_NL, 1'b0);
			end
			9: send_char(blank_byte(), 1'b0);
			10: send_char(8'($urandom_range(0, 255)), 1'b0);
			default: begin
				if ($urandom_range(0, 2) == 0)
					send_char(8'h00, 1'b1);
				else
					send_char(CH_NL, 1'b0);
			end
		endcase
	endtask

	// ---- tests ----

	task automatic test_byte_extremes();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_SLASH, 1'b0);
		send_char(8'h00, 1'b1);
		drain_results();
	endtask

	task automatic test_comments();
		send_text("/*/*/");
		send_text("//x");
		send_char(8'h00, 1'b1);
		drain_results();
	endtask

	task automatic test_quoted();
		send_text("\"\\\"\"\"\"\n");
		drain_results();
	endtask

	task automatic test_words();
		send_text("/\" a/b\n");
		drain_results();
	endtask

	task automatic test_random_stream(input int n);
		int stop_at;
		stop_at = chars_sent + n;
		gaps_on = 1'b1;
		while (chars_sent < stop_at)
			send_random_piece();
		drain_results();
	endtask

	task automatic test_steady_stream(input int n);
		int stop_at;
		stop_at = chars_sent + n;
		gaps_on = 1'b0;
		while (chars_sent < stop_at)
			send_random_piece();
		drain_results();
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		gaps_on  = 1'b0;
		hold_len = HOLD_CYCLES;
		send_text("abcdefghijklmn \"opq\"\n");
		drain_results();
		gaps_on = 1'b1;
	endtask

	// ---- tok side ----

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	initial begin : tok_sink
		int   wait_cycles;
		tok_t want;
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				wait_cycles = hold_len;
				hold_len    = 0;
			end else begin
				wait_cycles = gaps_on ? $urandom_range(0, 7) : 0;
			end
			if (wait_cycles > 0) begin
				tok_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			tok_stall <= 1'b0;
			do @(posedge clk); while (tok_valid !== 1'b1);
			if (expected_toks.size() == 0) begin
				$display("%0t: unexpected request: expected none actual %p", $time, tok);
				errors++;
			end else begin
				want = expected_toks.pop_front();
				check_field("kind", 8'(want.kind), 8'(tok.kind));
				check_field("token_byte", want.token_byte, tok.token_byte);
				check_field("byte_valid", 8'(want.byte_valid), 8'(tok.byte_valid));
				check_field("token_end", 8'(want.token_end), 8'(tok.token_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((chr_valid && chr_stall === 1'b0) || (tok_valid === 1'b1 && !tok_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_byte_extremes();
		test_comments();
		test_quoted();
		test_words();
		test_random_stream(30);
		test_backpressure();
		test_steady_stream(15);
		test_random_stream(10);
		if (expected_toks.size() != 0) begin
			$display("%0t: %0d requests expected but never seen", $time,
				expected_toks.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/oft_pkg.sv
rtl/core/oft_step.sv
rtl/core/oft_rbuf.sv
rtl/core/option_file_tokenizer_unit.sv
tb/option_file_tokenizer_unit_tb.sv
